[hw/rtl/mpq_pkg.sv]
package mpq_pkg;

   // Field widths fixed by the interface
   localparam int DataW      = 32;
   localparam int ReqW       = 2;
   localparam int StatusW    = 2;
   localparam int CountOutW  = 8;

   // Default queue depth
   localparam int DepthDefault = 128;

   typedef enum logic [ReqW-1:0] {
      REQ_INSERT  = 2'd0,
      REQ_EXTRACT = 2'd1,
      REQ_PEEK    = 2'd2,
      REQ_NOP     = 2'd3
   } req_code_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_SHIFT,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       ins_write;
      logic       res_set;
      status_type res_code;
      logic       scan_start;
      logic       scan_step;
      logic       pick;
      logic       shift_start;
      logic       shift_step;
      logic       count_dec;
      logic       rsp_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic empty;
      logic scan_last;
      logic pick_last;
      logic shift_last;
   } dp_status_type;

endpackage

[hw/rtl/max_priority_queue_unsorted.sv]
// Max-priority queue of up to DEPTH (payload, priority) entries kept unsorted in one
// single-port-read RAM in insertion order. Insert appends at the fill count, or
// reports full. Peek and extract scan every held entry for the highest signed
// priority (earliest wins a tie); extract then copies each later entry down one
// slot. Every request yields one result item with status, entry, count and empty
// flag. Items are taken one at a time; the RAM moves one entry per cycle, so an
// insert, an unused code or an empty peek/extract goes straight to its result, a
// peek scans every held entry, and an extract also shifts each entry after the one
// taken. A new item is accepted while the previous result still waits.
module max_priority_queue_unsorted #(
   parameter int DEPTH = mpq_pkg::DepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mpq_pkg::ReqW-1:0]          req_type,
   input  logic signed [mpq_pkg::DataW-1:0]  req_in_data,
   input  logic signed [mpq_pkg::DataW-1:0]  req_in_priority,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mpq_pkg::StatusW-1:0]       rsp_status,
   output logic signed [mpq_pkg::DataW-1:0]  rsp_out_data,
   output logic signed [mpq_pkg::DataW-1:0]  rsp_out_priority,
   output logic [mpq_pkg::CountOutW-1:0]     rsp_entry_count,
   output logic                              rsp_queue_empty
);
   import mpq_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   mpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (dp_status)
   );

   mpq_datapath #(
      .Depth(DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (dp_status),
      .req_in_data      (req_in_data),
      .req_in_priority  (req_in_priority),
      .rsp_status       (rsp_status),
      .rsp_out_data     (rsp_out_data),
      .rsp_out_priority (rsp_out_priority),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_queue_empty  (rsp_queue_empty)
   );

endmodule

[hw/rtl/mpq_ram.sv]
module mpq_ram #(
   parameter int Width = 64,
   parameter int Depth = 128,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mpq_datapath.sv]
module mpq_datapath #(
   parameter int Depth = mpq_pkg::DepthDefault,
   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int CountW = $clog2(Depth + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mpq_pkg::cmd_type                  cmd,
   output mpq_pkg::dp_status_type            status,
   input  logic signed [mpq_pkg::DataW-1:0]  req_in_data,
   input  logic signed [mpq_pkg::DataW-1:0]  req_in_priority,
   output logic [mpq_pkg::StatusW-1:0]       rsp_status,
   output logic signed [mpq_pkg::DataW-1:0]  rsp_out_data,
   output logic signed [mpq_pkg::DataW-1:0]  rsp_out_priority,
   output logic [mpq_pkg::CountOutW-1:0]     rsp_entry_count,
   output logic                              rsp_queue_empty
);
   import mpq_pkg::*;

   localparam int EntryW = 2 * DataW;

   logic [CountW-1:0] count_ff, count_in;
   logic [AddrW-1:0]  idx_ff, idx_in;
   logic [AddrW-1:0]  best_idx_ff, best_idx_in;
   logic signed [DataW-1:0] best_data_ff, best_data_in;
   logic signed [DataW-1:0] best_prio_ff, best_prio_in;
   status_type              res_status_ff, res_status_in;
   logic signed [DataW-1:0] res_data_ff, res_data_in;
   logic signed [DataW-1:0] res_prio_ff, res_prio_in;
   logic [StatusW-1:0]      rsp_status_ff;
   logic signed [DataW-1:0] rsp_data_ff, rsp_prio_ff;
   logic [CountOutW-1:0]    rsp_count_ff;
   logic                    rsp_empty_ff;

   logic              ram_wr_en;
   logic [AddrW-1:0]  ram_wr_addr;
   logic [EntryW-1:0] ram_wr_data;
   logic [AddrW-1:0]  ram_rd_addr;
   logic [EntryW-1:0] ram_rd_data;
   logic signed [DataW-1:0] rd_data, rd_prio;
   logic              take;
   logic [CountW+CountOutW-1:0] count_wide;

   mpq_ram #(
      .Width(EntryW),
      .Depth(Depth)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_prio = ram_rd_data[EntryW-1:DataW];
   assign rd_data = ram_rd_data[DataW-1:0];

   // Status towards the controller
   assign status.full       = (count_ff == CountW'(Depth));
   assign status.empty      = (count_ff == '0);
   assign status.scan_last  = ((CountW'(idx_ff) + CountW'(1)) == count_ff);
   assign status.pick_last  = ((CountW'(best_idx_ff) + CountW'(1)) == count_ff);
   assign status.shift_last = ((CountW'(idx_ff) + CountW'(1)) == count_ff);

   // First entry always taken; later ones only on strictly higher priority
   assign take = (idx_ff == '0) || (rd_prio > best_prio_ff);

   // Drive the store ports
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AddrW-1:0];
      ram_wr_data = {req_in_priority, req_in_data};
      ram_rd_addr = idx_ff;
      if (cmd.ins_write) begin
         ram_wr_en = 1'b1;
      end
      if (cmd.shift_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = idx_ff - AddrW'(1);
         ram_wr_data = ram_rd_data;
      end
      if (cmd.scan_start) begin
         ram_rd_addr = '0;
      end else if (cmd.scan_step || cmd.shift_step) begin
         ram_rd_addr = idx_ff + AddrW'(1);
      end else if (cmd.shift_start) begin
         ram_rd_addr = best_idx_ff + AddrW'(1);
      end
   end

   // Advance index, count and best entry
   always_comb begin
      idx_in       = idx_ff;
      count_in     = count_ff;
      best_idx_in  = best_idx_ff;
      best_data_in = best_data_ff;
      best_prio_in = best_prio_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.scan_step || cmd.shift_step) begin
         idx_in = idx_ff + AddrW'(1);
      end else if (cmd.shift_start) begin
         idx_in = best_idx_ff + AddrW'(1);
      end
      if (cmd.scan_step && take) begin
         best_idx_in  = idx_ff;
         best_data_in = rd_data;
         best_prio_in = rd_prio;
      end
      if (cmd.ins_write) begin
         count_in = count_ff + CountW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CountW'(1);
      end
   end

   // Build the pending result
   always_comb begin
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_prio_in   = res_prio_ff;
      if (cmd.res_set) begin
         res_status_in = cmd.res_code;
         res_data_in   = '0;
         res_prio_in   = '0;
      end else if (cmd.pick) begin
         res_status_in = ST_OK;
         res_data_in   = best_data_ff;
         res_prio_in   = best_prio_ff;
      end
   end

   assign count_wide = {{CountOutW{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_data_ff  <= best_data_in;
      best_prio_ff  <= best_prio_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_prio_ff   <= res_prio_in;
      // Hold the output item until the controller loads a new one
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_prio_ff   <= res_prio_ff;
         rsp_count_ff  <= count_wide[CountOutW-1:0];
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_out_data     = rsp_data_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_queue_empty  = rsp_empty_ff;

endmodule

[hw/rtl/mpq_ctrl.sv]
module mpq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mpq_pkg::ReqW-1:0]      req_type,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mpq_pkg::cmd_type              cmd,
   input  mpq_pkg::dp_status_type        status
);
   import mpq_pkg::*;

   state_type    state_ff, state_in;
   logic         extract_ff, extract_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_free;
   req_code_type code;

   assign code     = req_code_type'(req_type);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in   = state_ff;
      extract_in = extract_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               extract_in = (code == REQ_EXTRACT);
               state_in   = S_DONE;
               if ((code == REQ_EXTRACT || code == REQ_PEEK) && !status.empty) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (status.scan_last) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            state_in = S_DONE;
            if (extract_ff && !status.pick_last) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (status.shift_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Commands and handshake outputs
   always_comb begin
      cmd       = '0;
      cmd.res_code = ST_OK;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (code)
                  REQ_INSERT: begin
                     cmd.res_set = 1'b1;
                     if (status.full) begin
                        cmd.res_code = ST_FULL;
                     end else begin
                        cmd.ins_write = 1'b1;
                     end
                  end
                  REQ_EXTRACT, REQ_PEEK: begin
                     if (status.empty) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = ST_EMPTY;
                     end else begin
                        cmd.scan_start = 1'b1;
                     end
                  end
                  default: begin
                     cmd.res_set = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            if (extract_ff) begin
               if (status.pick_last) begin
                  cmd.count_dec = 1'b1;
               end else begin
                  cmd.shift_start = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (status.shift_last) begin
               cmd.count_dec = 1'b1;
            end
         end
         S_DONE: begin
            cmd.rsp_load = rsp_free;
         end
         default: begin
            cmd.res_code = ST_OK;
         end
      endcase
   end

   // Output item valid: set on load, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         extract_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         extract_ff   <= extract_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sim/mpq_checker.sv]
`timescale 1ns / 100ps

module mpq_checker #(
   parameter int DEPTH = mpq_pkg::DepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [mpq_pkg::ReqW-1:0]          req_type,
   input  logic signed [mpq_pkg::DataW-1:0]  req_in_data,
   input  logic signed [mpq_pkg::DataW-1:0]  req_in_priority,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [mpq_pkg::StatusW-1:0]       rsp_status,
   input  logic signed [mpq_pkg::DataW-1:0]  rsp_out_data,
   input  logic signed [mpq_pkg::DataW-1:0]  rsp_out_priority,
   input  logic [mpq_pkg::CountOutW-1:0]     rsp_entry_count,
   input  logic                              rsp_queue_empty,
   output int                                error_count,
   output int                                pending_count,
   output int                                full_hits,
   output int                                empty_hits,
   output int                                peak_fill
);

   import mpq_pkg::*;

   typedef struct {
      status_type                st;
      logic signed [DataW-1:0]   data;
      logic signed [DataW-1:0]   prio;
      logic [CountOutW-1:0]      count;
      logic                      empty;
   } queue_answer_type;

   // Shadow copy of the queue contents, in insertion order
   logic signed [DataW-1:0] slot_payload [DEPTH];
   logic signed [DataW-1:0] slot_priority [DEPTH];
   int                      held;

   queue_answer_type answer_q [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      full_hits     = 0;
      empty_hits    = 0;
      peak_fill     = 0;
      held          = 0;
   end

   // Apply one request to the shadow queue and return the answer it should give
   function automatic queue_answer_type serve_request(req_code_type code,
                                                      logic signed [DataW-1:0] data_v,
                                                      logic signed [DataW-1:0] prio_v);
      queue_answer_type ans;
      int               best;
      ans.st   = ST_OK;
      ans.data = '0;
      ans.prio = '0;
      case (code)
         REQ_INSERT: begin
            if (held >= DEPTH) begin
               ans.st = ST_FULL;
            end else begin
               slot_payload[held]  = data_v;
               slot_priority[held] = prio_v;
               held++;
            end
         end
         REQ_EXTRACT, REQ_PEEK: begin
            if (held == 0) begin
               ans.st = ST_EMPTY;
            end else begin
               // earliest entry wins a tie, so only a strictly greater one replaces it
               best = 0;
               for (int i = 1; i < held; i++) begin
                  if (slot_priority[i] > slot_priority[best]) best = i;
               end
               ans.data = slot_payload[best];
               ans.prio = slot_priority[best];
               if (code == REQ_EXTRACT) begin
                  for (int i = best; i + 1 < held; i++) begin
                     slot_payload[i]  = slot_payload[i+1];
                     slot_priority[i] = slot_priority[i+1];
                  end
                  held--;
               end
            end
         end
         default: ;
      endcase
      ans.count = held[CountOutW-1:0];
      ans.empty = (held == 0);
      return ans;
   endfunction

   always @(posedge clock) begin
      queue_answer_type want;
      queue_answer_type fresh;
      int               mism;
      mism = 0;
      if (reset) begin
         held = 0;
         answer_q.delete();
      end else begin
         // compare the result first: it always belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               $error("result with no request outstanding: status %0d data %0d",
                      rsp_status, rsp_out_data);
               mism++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_status !== want.st) begin
                  $error("status: expected %0d, got %0d", want.st, rsp_status);
                  mism++;
               end
               if (rsp_out_data !== want.data) begin
                  $error("out_data: expected %0d, got %0d", want.data, rsp_out_data);
                  mism++;
               end
               if (rsp_out_priority !== want.prio) begin
                  $error("out_priority: expected %0d, got %0d", want.prio, rsp_out_priority);
                  mism++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
                  mism++;
               end
               if (rsp_queue_empty !== want.empty) begin
                  $error("queue_empty: expected %0d, got %0d", want.empty, rsp_queue_empty);
                  mism++;
               end
            end
         end
         if (mism != 0) error_count <= error_count + mism;
         // predict the answer to a newly taken request
         if (req_valid && !req_stall) begin
            fresh = serve_request(req_code_type'(req_type), req_in_data, req_in_priority);
            answer_q.push_back(fresh);
            if (fresh.st == ST_FULL) full_hits <= full_hits + 1;
            if (fresh.st == ST_EMPTY) empty_hits <= empty_hits + 1;
            if (held > peak_fill) peak_fill <= held;
         end
      end
      pending_count <= answer_q.size();
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   import mpq_pkg::*;

   localparam int QDEPTH        = DepthDefault;
   localparam int RANDOM_ITEMS  = 1425;
   localparam int TAIL_ITEMS    = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 2 * QDEPTH + 40;
   localparam int STALL_LIMIT   = 5000;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_stall;
   logic [ReqW-1:0]          req_type        = REQ_NOP;
   logic signed [DataW-1:0]  req_in_data     = '0;
   logic signed [DataW-1:0]  req_in_priority = '0;
   logic                     rsp_valid;
   logic                     rsp_stall       = 1'b0;
   logic [StatusW-1:0]       rsp_status;
   logic signed [DataW-1:0]  rsp_out_data;
   logic signed [DataW-1:0]  rsp_out_priority;
   logic [CountOutW-1:0]     rsp_entry_count;
   logic                     rsp_queue_empty;

   int error_count;
   int pending_count;
   int full_hits;
   int empty_hits;
   int peak_fill;
   int items_sent   = 0;
   int quiet_cycles = 0;
   bit tail_quiet   = 1'b0;
   bit hold_off_go  = 1'b0;

   max_priority_queue_unsorted #(
      .DEPTH (QDEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_in_data      (req_in_data),
      .req_in_priority  (req_in_priority),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_data     (rsp_out_data),
      .rsp_out_priority (rsp_out_priority),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_queue_empty  (rsp_queue_empty)
   );

   mpq_checker #(
      .DEPTH (QDEPTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_in_data      (req_in_data),
      .req_in_priority  (req_in_priority),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_data     (rsp_out_data),
      .rsp_out_priority (rsp_out_priority),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_queue_empty  (rsp_queue_empty),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .full_hits        (full_hits),
      .empty_hits       (empty_hits),
      .peak_fill        (peak_fill)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request, none in the tail
   initial begin
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_off_go = 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 15) == 0) begin
            // leave a clean stretch with no stall at all
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end
      end
   end

   // Offer one item, perhaps after an idle burst, and hold it until taken
   task automatic send_item(input req_code_type code, input logic [DataW-1:0] data_v,
                            input logic [DataW-1:0] prio_v);
      if (!tail_quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= code;
      req_in_data     <= data_v;
      req_in_priority <= prio_v;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   initial begin
      int                 phase;
      int                 phase_len;
      int                 insert_pct;
      int                 roll;
      int                 rnd_sent;
      req_code_type       code;
      logic [DataW-1:0]   dval;
      logic [DataW-1:0]   pval;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty queue, extremes, ties, unused code
      send_item(REQ_PEEK,    32'h0000_0000, 32'h0000_0000);
      send_item(REQ_EXTRACT, 32'h1234_5678, 32'h7FFF_FFFF);
      send_item(REQ_NOP,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(REQ_INSERT,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(REQ_INSERT,  32'h8000_0000, 32'h8000_0000);
      send_item(REQ_INSERT,  32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_item(REQ_INSERT,  32'h0000_0000, 32'hFFFF_FFFF);
      send_item(REQ_INSERT,  32'h0000_0001, 32'h0000_0000);
      send_item(REQ_PEEK,    32'hFFFF_FFFF, 32'h8000_0000);
      send_item(REQ_NOP,     32'h0000_0000, 32'h0000_0000);
      send_item(REQ_EXTRACT, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_EXTRACT, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_PEEK,    32'h0000_0000, 32'h0000_0000);
      send_item(REQ_EXTRACT, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_EXTRACT, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_EXTRACT, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_EXTRACT, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_INSERT,  32'h0000_0005, 32'h0000_0003);
      send_item(REQ_INSERT,  32'h0000_0006, 32'h0000_0003);
      send_item(REQ_INSERT,  32'h0000_0007, 32'h0000_0003);
      send_item(REQ_EXTRACT, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_NOP,     32'h5555_AAAA, 32'hAAAA_5555);
      send_item(REQ_EXTRACT, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_EXTRACT, 32'h0000_0000, 32'h0000_0000);
      send_item(REQ_PEEK,    32'h0000_0000, 32'h0000_0000);
      wait_drained();

      // Random: fill, fill, mix, drain, drain, mix, so the queue hits full and empty
      rnd_sent = 0;
      phase    = 0;
      while (rnd_sent < RANDOM_ITEMS) begin
         case (phase % 6)
            0, 1:    insert_pct = 85;
            3, 4:    insert_pct = 15;
            default: insert_pct = 50;
         endcase
         // hold the result side off once while requests keep coming
         if (phase == 3) hold_off_go = 1'b1;
         phase_len = $urandom_range(80, 140);
         for (int k = 0; k < phase_len && rnd_sent < RANDOM_ITEMS; k++) begin
            tail_quiet = (rnd_sent >= RANDOM_ITEMS - TAIL_ITEMS);
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) begin
               code = REQ_INSERT;
            end else begin
               roll = $urandom_range(0, 19);
               code = (roll < 12) ? REQ_EXTRACT : (roll < 19) ? REQ_PEEK : REQ_NOP;
            end
            dval = $urandom;
            // mix full-range priorities, a narrow band for ties, and the extremes
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
               pval = $urandom;
            end else if (roll < 8) begin
               pval = $urandom_range(0, 8) - 4;
            end else begin
               case ($urandom_range(0, 3))
                  0:       pval = 32'h7FFF_FFFF;
                  1:       pval = 32'h8000_0000;
                  2:       pval = 32'hFFFF_FFFF;
                  default: pval = 32'h0000_0000;
               endcase
            end
            send_item(code, dval, pval);
            rnd_sent++;
         end
         // pause the request side until every result is back
         if (!tail_quiet) wait_drained();
         phase++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d items over %0d random phases; queue peaked at %0d of %0d entries.",
               items_sent, phase, peak_fill, QDEPTH);
      $display("Saw %0d inserts refused as full and %0d reads of an empty queue.",
               full_hits, empty_hits);
      if (error_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
